// ===== rtl/core/dsim_pkg.sv =====
// Shared types, constants and codes for the dual source input merger.
package dsim_pkg;

  // Queue geometry
  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned STAMP_W     = 32;

  // Operation queue between front and back
  localparam int unsigned OPQ_DEPTH   = 2;
  localparam int unsigned OPQ_PTR_W   = $clog2(OPQ_DEPTH);
  localparam int unsigned OPQ_CNT_W   = $clog2(OPQ_DEPTH + 1);

  // Register file: one 32-bit register, word index in paddr[2]
  localparam int unsigned PADDR_W     = 3;
  localparam logic [PADDR_W-3:0] REG_LINK_MODE = '0;

  // Function codes of an input beat
  typedef enum logic [1:0] {
    FN_PUSH    = 2'd0,
    FN_PHASED  = 2'd1,
    FN_MERGED  = 2'd2,
    FN_SOURCE  = 2'd3
  } func_e;

  // Phase and link mode codes
  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_AB36 = 2'd1;
  localparam logic [1:0] LM_ZERO = 2'd0;
  localparam logic [1:0] LM_ONE  = 2'd1;

  // Classified operation kinds
  typedef enum logic [2:0] {
    OP_PUSH,
    OP_PUSH_BAD,
    OP_PHASED,
    OP_MERGED,
    OP_SOURCE
  } op_kind_e;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } back_state_e;

  typedef struct packed {
    logic [1:0] func;
    logic       source_remote;
    logic [1:0] phase;
    logic [1:0] in_length;
    logic [7:0] in_byte0;
    logic [7:0] in_byte1;
  } in_t;

  typedef struct packed {
    logic               push_accepted;
    logic [1:0]         out_length;
    logic [7:0]         out_byte0;
    logic [7:0]         out_byte1;
    logic [STAMP_W-1:0] out_sequence;
    logic               out_remote;
    logic               local_can_push;
    logic               remote_can_push;
  } out_t;

  typedef struct packed {
    op_kind_e   kind;
    logic       source_remote;
    logic [1:0] phase;
    logic [1:0] len;
    logic [7:0] b0;
    logic [7:0] b1;
  } op_t;

  // One stored queue entry
  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [1:0]         len;
    logic [7:0]         b0;
    logic [7:0]         b1;
  } ent_t;

endpackage

// ===== rtl/core/dsim_front.sv =====
// Front end: takes input beats and classifies them into operations.
module dsim_front import dsim_pkg::*; (
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_t      in_data_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output op_t      q_op_o
);

  // Stall only on a full operation queue
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;

  // Decode function and pre-check push length
  always_comb begin
    q_op_o.source_remote = in_data_i.source_remote;
    q_op_o.phase         = in_data_i.phase;
    q_op_o.len           = in_data_i.in_length;
    q_op_o.b0            = in_data_i.in_byte0;
    q_op_o.b1            = in_data_i.in_byte1;
    unique case (func_e'(in_data_i.func))
      FN_PUSH: begin
        q_op_o.kind = ((in_data_i.in_length == 2'd1) || (in_data_i.in_length == 2'd2))
                      ? OP_PUSH : OP_PUSH_BAD;
      end
      FN_PHASED: q_op_o.kind = OP_PHASED;
      FN_MERGED: q_op_o.kind = OP_MERGED;
      FN_SOURCE: q_op_o.kind = OP_SOURCE;
      default:   q_op_o.kind = OP_PUSH_BAD;
    endcase
  end

endmodule

// ===== rtl/core/dsim_opq.sv =====
// Short operation queue that decouples the front end from the back end.
module dsim_opq import dsim_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  op_t      op_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output op_t      op_o
);

  op_t                  entry_q [OPQ_DEPTH];
  logic [OPQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [OPQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [OPQ_CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == OPQ_CNT_W'(OPQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign op_o    = entry_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Payload storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

// ===== rtl/core/dsim_back.sv =====
// Back end: holds both item queues, executes operations, registers results.
module dsim_back import dsim_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] link_mode_i,
  input  logic       op_valid_i,
  input  op_t        op_i,
  output logic       op_pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_t       out_data_o
);

  localparam int unsigned SUM_W = CNT_W + 1;

  // Item memories, read data registered
  ent_t l_mem [QUEUE_DEPTH];
  ent_t r_mem [QUEUE_DEPTH];
  ent_t l_rd_q, r_rd_q;

  back_state_e        state_q, state_d;
  op_t                op_q, op_d;
  logic [PTR_W-1:0]   l_head_q, l_head_d, r_head_q, r_head_d;
  logic [CNT_W-1:0]   l_cnt_q, l_cnt_d, r_cnt_q, r_cnt_d;
  logic [STAMP_W-1:0] stamp_q, stamp_d;
  logic               out_valid_q, out_valid_d;
  out_t               out_data_q, out_data_d;

  logic               exec;
  logic               l_ne, r_ne, l_room, r_room, poll;
  logic               take_l, take_r, push_l, push_r;
  logic [STAMP_W-1:0] stamp_diff;
  logic [SUM_W-1:0]   l_sum, r_sum;
  logic [PTR_W-1:0]   l_tail, r_tail;
  ent_t               wr_ent;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign exec       = (state_q == BK_EXEC);
  assign l_ne       = (l_cnt_q != '0);
  assign r_ne       = (r_cnt_q != '0);
  assign l_room     = (l_cnt_q < CNT_W'(QUEUE_DEPTH));
  assign r_room     = (r_cnt_q < CNT_W'(QUEUE_DEPTH));
  assign poll       = (op_q.phase == PH_AB36) ? (link_mode_i != LM_ONE)
                                              : (link_mode_i == LM_ZERO);
  assign stamp_diff = l_rd_q.stamp - r_rd_q.stamp;

  // Tail slot: head plus count, wrapped once
  assign l_sum  = SUM_W'(l_head_q) + SUM_W'(l_cnt_q);
  assign r_sum  = SUM_W'(r_head_q) + SUM_W'(r_cnt_q);
  assign l_tail = (l_sum >= SUM_W'(QUEUE_DEPTH)) ? PTR_W'(l_sum - SUM_W'(QUEUE_DEPTH))
                                                 : PTR_W'(l_sum);
  assign r_tail = (r_sum >= SUM_W'(QUEUE_DEPTH)) ? PTR_W'(r_sum - SUM_W'(QUEUE_DEPTH))
                                                 : PTR_W'(r_sum);

  assign wr_ent = '{stamp: stamp_q, len: op_q.len, b0: op_q.b0, b1: op_q.b1};

  // Which queues this operation pops or pushes
  always_comb begin
    take_l = 1'b0;
    take_r = 1'b0;
    push_l = 1'b0;
    push_r = 1'b0;
    if (exec) begin
      case (op_q.kind)
        OP_PUSH: begin
          push_l = !op_q.source_remote && l_room;
          push_r = op_q.source_remote && r_room;
        end
        OP_PHASED: begin
          take_l = l_ne;
          take_r = !((op_q.phase == PH_WAIT) && l_ne) && poll && r_ne;
        end
        OP_MERGED: begin
          // older head by wrap-aware stamp difference
          if (l_ne && r_ne) begin
            take_l = stamp_diff[STAMP_W-1];
            take_r = !stamp_diff[STAMP_W-1];
          end else begin
            take_l = l_ne;
            take_r = r_ne;
          end
        end
        OP_SOURCE: begin
          take_l = !op_q.source_remote && l_ne;
          take_r = op_q.source_remote && r_ne;
        end
        default: ;
      endcase
    end
  end

  // Sequencer, pointer updates and result formation
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    op_pop_o    = 1'b0;
    l_head_d    = l_head_q;
    r_head_d    = r_head_q;
    l_cnt_d     = l_cnt_q;
    r_cnt_d     = r_cnt_q;
    stamp_d     = stamp_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;

    if (take_l) begin
      l_cnt_d  = l_cnt_q - 1'b1;
      l_head_d = (l_cnt_q == CNT_W'(1)) ? '0 : ptr_inc(l_head_q);
    end
    if (take_r) begin
      r_cnt_d  = r_cnt_q - 1'b1;
      r_head_d = (r_cnt_q == CNT_W'(1)) ? '0 : ptr_inc(r_head_q);
    end
    if (push_l) begin
      l_cnt_d = l_cnt_q + 1'b1;
    end
    if (push_r) begin
      r_cnt_d = r_cnt_q + 1'b1;
    end
    if (push_l || push_r) begin
      stamp_d = stamp_q + 1'b1;
    end

    unique case (state_q)
      BK_IDLE: begin
        // start only when the result register is free by the execute cycle
        if (op_valid_i && (!out_valid_q || !out_stall_i)) begin
          op_pop_o = 1'b1;
          op_d     = op_i;
          state_d  = BK_EXEC;
        end
      end
      BK_EXEC: begin
        out_valid_d                = 1'b1;
        out_data_d                 = '0;
        out_data_d.push_accepted   = push_l || push_r;
        if (take_r) begin
          out_data_d.out_length   = r_rd_q.len;
          out_data_d.out_byte0    = r_rd_q.b0;
          out_data_d.out_byte1    = r_rd_q.b1;
          out_data_d.out_sequence = r_rd_q.stamp;
          out_data_d.out_remote   = 1'b1;
        end else if (take_l) begin
          out_data_d.out_length   = l_rd_q.len;
          out_data_d.out_byte0    = l_rd_q.b0;
          out_data_d.out_byte1    = l_rd_q.b1;
          out_data_d.out_sequence = l_rd_q.stamp;
        end
        out_data_d.local_can_push  = (l_cnt_d < CNT_W'(QUEUE_DEPTH));
        out_data_d.remote_can_push = (r_cnt_d < CNT_W'(QUEUE_DEPTH));
        state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      l_head_q    <= '0;
      r_head_q    <= '0;
      l_cnt_q     <= '0;
      r_cnt_q     <= '0;
      stamp_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      l_head_q    <= l_head_d;
      r_head_q    <= r_head_d;
      l_cnt_q     <= l_cnt_d;
      r_cnt_q     <= r_cnt_d;
      stamp_q     <= stamp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    out_data_q <= out_data_d;
  end

  // Local queue memory: write at tail, read at head
  always_ff @(posedge clk_i) begin
    if (push_l) begin
      l_mem[l_tail] <= wr_ent;
    end
    l_rd_q <= l_mem[l_head_q];
  end

  // Remote queue memory
  always_ff @(posedge clk_i) begin
    if (push_r) begin
      r_mem[r_tail] <= wr_ent;
    end
    r_rd_q <= r_mem[r_head_q];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/core/dual_source_input_merger.sv =====
// Top level of the dual source input merger: register port and block wiring.
//
//  Channel  Direction  Handshake                 Beat
//  in       input      in_valid_i / in_stall_o   in_t: func, source, phase, length, bytes
//  out      output     out_valid_o / out_stall_i out_t: popped item, push status, room
//  config   input      psel/penable/pwrite, APB  link_mode at byte address 0
//
//  The back end reads both queue heads from their memories in its idle state, then
//  executes the operation and loads the result register in its execute state.
//  A two-entry operation queue lets input beats land while the back end works.
//  Reset clears pointers, counts, the stamp counter and link_mode; queue
//  memories are not cleared and need no clearing pass.
//  A stalled result holds; the back end starts a new operation only when the
//  result register is empty or being taken in the same cycle.
module dual_source_input_merger import dsim_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_t               out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [1:0] link_mode_q;
  logic       reg_sel;
  logic       opq_full, opq_push;
  op_t        front_op, back_op;
  logic       back_valid, back_pop;

  // Register port
  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1:2] == REG_LINK_MODE);
  assign prdata  = reg_sel ? {30'b0, link_mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_mode_q <= LM_ZERO;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      link_mode_q <= pwdata[1:0];
    end
  end

  dsim_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (opq_full),
    .q_push_o   (opq_push),
    .q_op_o     (front_op)
  );

  dsim_opq u_opq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (opq_push),
    .op_i    (front_op),
    .full_o  (opq_full),
    .pop_i   (back_pop),
    .valid_o (back_valid),
    .op_o    (back_op)
  );

  dsim_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .link_mode_i (link_mode_q),
    .op_valid_i  (back_valid),
    .op_i        (back_op),
    .op_pop_o    (back_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/core/dsim_checker.sv =====
// Port-level checker for the dual source input merger, bound to the top level.
module dsim_checker import dsim_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input out_t               out_data_o
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed under stall");

  // Push results carry no popped item
  a_push_no_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.push_accepted |->
      out_data_o.out_length == 2'd0 && out_data_o.out_sequence == '0 &&
      !out_data_o.out_remote)
    else $error("push result carries item fields");

  // A popped item always has length one or two
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.out_length != 2'd3)
    else $error("illegal popped length");

  // An empty pop answers a zero item
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_length == 2'd0 |->
      out_data_o.out_byte0 == 8'd0 && out_data_o.out_byte1 == 8'd0 &&
      out_data_o.out_sequence == '0 && !out_data_o.out_remote)
    else $error("empty pop with nonzero fields");

  // No result without an earlier accepted input beat right after reset
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result beat right out of reset");

endmodule

bind dual_source_input_merger dsim_checker u_dsim_checker (.*);

// ===== sim/tb.sv =====
// Self-checking testbench for the dual source input merger: directed and random traffic.
module tb import dsim_pkg::*; ();

  localparam int SRC_LOCAL  = 0;
  localparam int SRC_REMOTE = 1;

  // One stored entry of the predictor's queues
  typedef struct packed {
    logic [31:0] stamp;
    logic [1:0]  len;
    logic [7:0]  b0;
    logic [7:0]  b1;
  } q_entry_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  in_t                in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  out_t               out_data_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // Predictor state
  q_entry_t    fifo_mem [2][QUEUE_DEPTH];
  int unsigned fifo_head [2];
  int unsigned fifo_count [2];
  logic [31:0] stamp_counter;
  logic [1:0]  link_mode_model;

  out_t pending_results[$];
  int   fail_count;
  bit   quiet_mode;
  int   stall_left;

  dual_source_input_merger u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Clock: period 10
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_failure(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    fail_count++;
  endtask

  // Pop the head of one predictor queue; zero item when empty
  function automatic out_t pop_entry(int src);
    out_t     res;
    q_entry_t e;
    res = '0;
    if (fifo_count[src] != 0) begin
      e = fifo_mem[src][fifo_head[src]];
      res.out_length   = e.len;
      res.out_byte0    = e.b0;
      res.out_byte1    = e.b1;
      res.out_sequence = e.stamp;
      res.out_remote   = (src == SRC_REMOTE);
      fifo_head[src]   = (fifo_head[src] + 1) % QUEUE_DEPTH;
      fifo_count[src]--;
      if (fifo_count[src] == 0) fifo_head[src] = 0;
    end
    return res;
  endfunction

  // Work out the result of one accepted beat and advance the predictor
  function automatic out_t predict_merger_result(in_t beat);
    out_t        res;
    int          src;
    bit          poll;
    logic [31:0] stamp_diff;
    res = '0;
    src = beat.source_remote ? SRC_REMOTE : SRC_LOCAL;
    case (func_e'(beat.func))
      FN_PUSH: begin
        if (beat.in_length inside {2'd1, 2'd2} && fifo_count[src] < QUEUE_DEPTH) begin
          fifo_mem[src][(fifo_head[src] + fifo_count[src]) % QUEUE_DEPTH] =
            '{stamp: stamp_counter, len: beat.in_length, b0: beat.in_byte0,
              b1: beat.in_byte1};
          stamp_counter = stamp_counter + 32'd1;
          fifo_count[src]++;
          res.push_accepted = 1'b1;
        end
      end
      FN_PHASED: begin
        res = pop_entry(SRC_LOCAL);
        if (!(beat.phase == PH_WAIT && res.out_length != 0)) begin
          if (beat.phase == PH_AB36) poll = (link_mode_model != LM_ONE);
          else                       poll = (link_mode_model == LM_ZERO);
          if (poll && fifo_count[SRC_REMOTE] != 0) res = pop_entry(SRC_REMOTE);
        end
      end
      FN_MERGED: begin
        if (fifo_count[SRC_LOCAL] != 0 && fifo_count[SRC_REMOTE] != 0) begin
          // older head wins, by wrap-aware stamp difference
          stamp_diff = fifo_mem[SRC_LOCAL][fifo_head[SRC_LOCAL]].stamp -
                       fifo_mem[SRC_REMOTE][fifo_head[SRC_REMOTE]].stamp;
          res = pop_entry(stamp_diff[31] ? SRC_LOCAL : SRC_REMOTE);
        end else if (fifo_count[SRC_LOCAL] != 0) begin
          res = pop_entry(SRC_LOCAL);
        end else begin
          res = pop_entry(SRC_REMOTE);
        end
      end
      default: begin
        res = pop_entry(src);
      end
    endcase
    res.local_can_push  = (fifo_count[SRC_LOCAL] < QUEUE_DEPTH);
    res.remote_can_push = (fifo_count[SRC_REMOTE] < QUEUE_DEPTH);
    return res;
  endfunction

  function automatic in_t make_beat(func_e fn, logic src, logic [1:0] ph, logic [1:0] len,
                                    logic [7:0] b0, logic [7:0] b1);
    in_t beat;
    beat.func          = fn;
    beat.source_remote = src;
    beat.phase         = ph;
    beat.in_length     = len;
    beat.in_byte0      = b0;
    beat.in_byte1      = b1;
    return beat;
  endfunction

  // Drive one beat and hold it until accepted; the result is predicted at acceptance
  task automatic send_beat(in_t beat);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i  = beat;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    pending_results.push_back(predict_merger_result(beat));
  endtask

  task automatic sender_gap(int cycles);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Let every outstanding result drain before touching the register
  task automatic wait_idle();
    sender_gap(1);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write of link_mode, then read it back
  task automatic write_link_mode(logic [1:0] mode);
    wait_idle();
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {REG_LINK_MODE, 2'b00};
    pwdata  = {30'($urandom), mode};
    @(negedge clk_i);
    penable = 1'b1;
    forever begin
      @(posedge clk_i);
      if (pready) break;
    end
    link_mode_model = mode;
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    forever begin
      @(posedge clk_i);
      if (pready) break;
    end
    if (prdata[1:0] !== mode)
      report_failure($sformatf("link_mode read %0d, wrote %0d", prdata[1:0], mode));
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic test_empty_pops();
    send_beat(make_beat(FN_PHASED, 1'b0, PH_WAIT, 2'd0, 8'h00, 8'h00));
    send_beat(make_beat(FN_PHASED, 1'b1, PH_AB36, 2'd3, 8'hff, 8'hff));
    send_beat(make_beat(FN_MERGED, 1'b0, 2'd2, 2'd0, 8'h00, 8'h00));
    send_beat(make_beat(FN_SOURCE, 1'b0, 2'd3, 2'd0, 8'h00, 8'h00));
    send_beat(make_beat(FN_SOURCE, 1'b1, 2'd0, 2'd0, 8'h00, 8'h00));
  endtask

  // Bad lengths are rejected; good ones store both bytes as given
  task automatic test_push_lengths();
    send_beat(make_beat(FN_PUSH, 1'b0, PH_WAIT, 2'd0, 8'h5a, 8'ha5));
    send_beat(make_beat(FN_PUSH, 1'b1, 2'd3, 2'd3, 8'hff, 8'hff));
    send_beat(make_beat(FN_PUSH, 1'b0, PH_WAIT, 2'd1, 8'h00, 8'hff));
    send_beat(make_beat(FN_PUSH, 1'b0, PH_AB36, 2'd2, 8'hff, 8'h00));
    send_beat(make_beat(FN_PUSH, 1'b1, 2'd2, 2'd2, 8'hff, 8'hff));
    send_beat(make_beat(FN_PUSH, 1'b1, 2'd3, 2'd1, 8'h00, 8'h00));
  endtask

  task automatic test_merged_order();
    send_beat(make_beat(FN_MERGED, 1'b1, PH_WAIT, 2'd0, 8'h00, 8'h00));
    send_beat(make_beat(FN_SOURCE, 1'b1, PH_WAIT, 2'd0, 8'h00, 8'h00));
    send_beat(make_beat(FN_MERGED, 1'b0, PH_AB36, 2'd0, 8'h00, 8'h00));
    send_beat(make_beat(FN_MERGED, 1'b0, 2'd2, 2'd0, 8'h00, 8'h00));
  endtask

  // Remote polling across phases and link modes, including a dropped local item
  task automatic test_phased_select();
    write_link_mode(LM_ONE);
    send_beat(make_beat(FN_PUSH, 1'b0, PH_WAIT, 2'd2, 8'h11, 8'h22));
    send_beat(make_beat(FN_PUSH, 1'b1, PH_WAIT, 2'd2, 8'h33, 8'h44));
    send_beat(make_beat(FN_PHASED, 1'b0, PH_AB36, 2'd0, 8'h00, 8'h00));
    send_beat(make_beat(FN_PHASED, 1'b0, PH_WAIT, 2'd0, 8'h00, 8'h00));
    write_link_mode(2'd3);
    send_beat(make_beat(FN_PHASED, 1'b0, 2'd3, 2'd0, 8'h00, 8'h00));
    send_beat(make_beat(FN_PUSH, 1'b0, PH_WAIT, 2'd1, 8'h55, 8'h66));
    send_beat(make_beat(FN_PHASED, 1'b0, PH_AB36, 2'd0, 8'h00, 8'h00));
    write_link_mode(LM_ZERO);
    send_beat(make_beat(FN_PUSH, 1'b0, PH_WAIT, 2'd1, 8'h77, 8'h88));
    send_beat(make_beat(FN_PUSH, 1'b1, PH_WAIT, 2'd1, 8'h99, 8'haa));
    send_beat(make_beat(FN_PHASED, 1'b0, PH_WAIT, 2'd0, 8'h00, 8'h00));
    send_beat(make_beat(FN_PHASED, 1'b0, 2'd2, 2'd0, 8'h00, 8'h00));
  endtask

  // Random traffic under one link mode; push_pct and remote_pct steer queue fill
  task automatic test_random_traffic(logic [1:0] mode, int count, int push_pct, int remote_pct,
                                     bit no_idle);
    in_t beat;
    write_link_mode(mode);
    quiet_mode = no_idle;
    repeat (count) begin
      beat = in_t'($bits(in_t)'($urandom));
      beat.source_remote = ($urandom_range(0, 99) < remote_pct);
      if ($urandom_range(0, 99) < push_pct) begin
        beat.func = FN_PUSH;
        if ($urandom_range(0, 9) == 0)
          beat.in_length = $urandom_range(0, 1) ? 2'd3 : 2'd0;
        else
          beat.in_length = 2'($urandom_range(1, 2));
      end else begin
        beat.func = 2'($urandom_range(FN_PHASED, FN_SOURCE));
      end
      if (!no_idle && $urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 7));
      send_beat(beat);
    end
  endtask

  // Receiver stall in random bursts; none while quiet_mode is set
  always @(negedge clk_i) begin
    if (quiet_mode) begin
      out_stall_i = 1'b0;
      stall_left  = 0;
    end else if (stall_left > 0) begin
      out_stall_i = 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall_i = 1'b1;
      stall_left  = $urandom_range(1, 7) - 1;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  // Compare each accepted result beat with the oldest prediction
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_failure($sformatf("result beat with nothing pending: %h", out_data_o));
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.push_accepted !== want.push_accepted)
          report_failure($sformatf("push_accepted got %0d want %0d",
                                   out_data_o.push_accepted, want.push_accepted));
        if (out_data_o.out_length !== want.out_length)
          report_failure($sformatf("out_length got %0d want %0d",
                                   out_data_o.out_length, want.out_length));
        if (out_data_o.out_byte0 !== want.out_byte0)
          report_failure($sformatf("out_byte0 got %h want %h",
                                   out_data_o.out_byte0, want.out_byte0));
        if (out_data_o.out_byte1 !== want.out_byte1)
          report_failure($sformatf("out_byte1 got %h want %h",
                                   out_data_o.out_byte1, want.out_byte1));
        if (out_data_o.out_sequence !== want.out_sequence)
          report_failure($sformatf("out_sequence got %0d want %0d",
                                   out_data_o.out_sequence, want.out_sequence));
        if (out_data_o.out_remote !== want.out_remote)
          report_failure($sformatf("out_remote got %0d want %0d",
                                   out_data_o.out_remote, want.out_remote));
        if (out_data_o.local_can_push !== want.local_can_push)
          report_failure($sformatf("local_can_push got %0d want %0d",
                                   out_data_o.local_can_push, want.local_can_push));
        if (out_data_o.remote_can_push !== want.remote_can_push)
          report_failure($sformatf("remote_can_push got %0d want %0d",
                                   out_data_o.remote_can_push, want.remote_can_push));
      end
    end
  end

  // Hard stop if the run hangs
  initial begin
    #3000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int drain_cycles;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    fail_count  = 0;
    quiet_mode  = 1'b0;
    stall_left  = 0;
    fifo_head   = '{0, 0};
    fifo_count  = '{0, 0};
    stamp_counter   = '0;
    link_mode_model = LM_ZERO;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_pops();
    test_push_lengths();
    test_merged_order();
    test_phased_select();
    test_random_traffic(LM_ONE, 120, 90, 15, 1'b0);
    test_random_traffic(LM_ZERO, 100, 20, 50, 1'b0);
    test_random_traffic(2'd2, 120, 90, 85, 1'b0);
    test_random_traffic(2'd3, 100, 15, 50, 1'b0);
    test_random_traffic(LM_ZERO, 110, 50, 50, 1'b1);

    // Drain, with a bound
    sender_gap(1);
    drain_cycles = 0;
    while (pending_results.size() != 0 && drain_cycles < 20000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (20) @(posedge clk_i);
    while (pending_results.size() != 0) begin
      report_failure($sformatf("result never arrived: %h", pending_results.pop_front()));
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/dsim_pkg.sv
rtl/core/dsim_front.sv
rtl/core/dsim_opq.sv
rtl/core/dsim_back.sv
rtl/core/dual_source_input_merger.sv
rtl/core/dsim_checker.sv
sim/tb.sv
